// ===== design/rcac_pkg.sv =====
`timescale 1ns / 1ps
// rcac_pkg: shared types, constants and helpers for the rounded corner
// coverage pipeline. No dependencies.

package rcac_pkg;

  localparam int RAD_W      = 10;
  localparam int SEC_W      = 3;
  localparam int ALPHA_W    = 8;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int DEN_W      = RAD_W + 1;
  localparam int PROD_W     = DEN_W + ALPHA_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RAD_W;
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = ALPHA_W / DIV_BITS;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BORDER_THICK  = 2'd2;

  localparam logic [SEC_W-1:0] SEC_TL = 3'd0;
  localparam logic [SEC_W-1:0] SEC_TR = 3'd1;
  localparam logic [SEC_W-1:0] SEC_BL = 3'd2;
  localparam logic [SEC_W-1:0] SEC_BR = 3'd3;

  localparam logic [RAD_W-1:0] RADIUS_RST = 10'd8;
  localparam logic [RAD_W-1:0] THICK_RST  = 10'd1;

  typedef enum logic [1:0] {
    MODE_SQUARE = 2'd0,
    MODE_ROUND  = 2'd1,
    MODE_BORDER = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  // raw register view, used at the head of the pipe
  typedef struct packed {
    mode_e             mode;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

  // squared edge thresholds and ramp widths, used further down the pipe
  typedef struct packed {
    logic [SQ_W-1:0]   o_in;
    logic [SQ_W-1:0]   o_out;
    logic [SQ_W-1:0]   i_in;
    logic [SQ_W-1:0]   i_out;
    logic [DEN_W-1:0]  den_o;
    logic [DEN_W-1:0]  den_i;
  } geom_t;

  // fixed result that skips the ramp
  typedef struct packed {
    logic               byp;
    logic [ALPHA_W-1:0] alpha;
  } tag_t;

  function automatic int mag_width(int cb);
    return ((cb > RAD_W) ? cb : RAD_W) + 1;
  endfunction

  // (x-1)^2 with x = 0 giving 1
  function automatic logic [SQ_W-1:0] sq_less_one(logic [RAD_W-1:0] x);
    logic [RAD_W-1:0] xm;
    xm = x - RAD_W'(1);
    if (x == '0) begin
      return SQ_W'(1);
    end
    return xm * xm;
  endfunction

endpackage

// ===== design/rounded_corner_alpha_coverage.sv =====
`timescale 1ns / 1ps
// rounded_corner_alpha_coverage: coverage alpha for a pixel of a corner region.
// Pipeline: 9 register stages (3 distance stages, 2 band stages, 4 divider stages
// of two quotient bits each); alpha_o comes from the last divider stage.
// Throughput: one request per cycle while out_stall_i is low;
// every stage holds its own valid bit.
// Reset: asynchronous active low; clears the pipe, mode square, radius 8, thickness 1.
// Depends on rcac_pkg, rcac_cfg, rcac_dist, rcac_classify, rcac_div_stage.

module rounded_corner_alpha_coverage
  import rcac_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [COORD_BITS-1:0] pos_x_i,
  input  logic [COORD_BITS-1:0] pos_y_i,
  input  logic [SEC_W-1:0]      section_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [ALPHA_W-1:0]    alpha_o
);

  localparam int DW = 2 * mag_width(COORD_BITS) + 1;

  cfg_t          cfg;
  geom_t         geom;
  logic          in_ready;
  logic          dist_vld, dist_rdy;
  logic [DW-1:0] dist_sq;
  mode_e         dist_mode;
  tag_t          dist_tag;

  logic               dv_vld [DIV_STAGES+1];
  logic               dv_rdy [DIV_STAGES+1];
  logic [PROD_W-1:0]  dv_rem [DIV_STAGES+1];
  logic [DEN_W-1:0]   dv_den [DIV_STAGES+1];
  logic [ALPHA_W-1:0] dv_quo [DIV_STAGES+1];
  logic               dv_byp [DIV_STAGES+1];

  rcac_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .geom_o      (geom)
  );

  rcac_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready),
    .pos_x_i     (pos_x_i),
    .pos_y_i     (pos_y_i),
    .section_i   (section_i),
    .cfg_i       (cfg),
    .out_valid_o (dist_vld),
    .out_ready_i (dist_rdy),
    .dist_o      (dist_sq),
    .mode_o      (dist_mode),
    .tag_o       (dist_tag)
  );

  rcac_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dist_vld),
    .in_ready_o  (dist_rdy),
    .dist_i      (dist_sq),
    .mode_i      (dist_mode),
    .tag_i       (dist_tag),
    .geom_i      (geom),
    .out_valid_o (dv_vld[0]),
    .out_ready_i (dv_rdy[0]),
    .rem_o       (dv_rem[0]),
    .den_o       (dv_den[0]),
    .quo_o       (dv_quo[0]),
    .byp_o       (dv_byp[0])
  );

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    rcac_div_stage #(
      .BIT_HI (ALPHA_W - 1 - g * DIV_BITS)
    ) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (dv_vld[g]),
      .in_ready_o  (dv_rdy[g]),
      .rem_i       (dv_rem[g]),
      .den_i       (dv_den[g]),
      .quo_i       (dv_quo[g]),
      .byp_i       (dv_byp[g]),
      .out_valid_o (dv_vld[g+1]),
      .out_ready_i (dv_rdy[g+1]),
      .rem_o       (dv_rem[g+1]),
      .den_o       (dv_den[g+1]),
      .quo_o       (dv_quo[g+1]),
      .byp_o       (dv_byp[g+1])
    );
  end

  assign in_stall_o           = !in_ready;
  assign dv_rdy[DIV_STAGES]   = !out_stall_i;
  assign out_valid_o          = dv_vld[DIV_STAGES];
  assign alpha_o              = dv_quo[DIV_STAGES];

endmodule

// ===== design/rcac_cfg.sv =====
`timescale 1ns / 1ps
// rcac_cfg: configuration registers and registered edge thresholds.
// Depends on rcac_pkg.

module rcac_cfg
  import rcac_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o,
  output geom_t                 geom_o
);

  mode_e            mode_q;
  logic [RAD_W-1:0] radius_q;
  logic [RAD_W-1:0] thick_q;
  geom_t            geom_d, geom_q;
  logic [RAD_W-1:0] inner_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_SQUARE;
      radius_q <= RADIUS_RST;
      thick_q  <= THICK_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SHAPE_MODE:    mode_q   <= mode_e'(cfg_wdata_i[1:0]);
        CFG_CORNER_RADIUS: radius_q <= cfg_wdata_i;
        CFG_BORDER_THICK:  thick_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    inner_r      = (radius_q < thick_q) ? '0 : radius_q - thick_q;
    geom_d.o_out = radius_q * radius_q;
    geom_d.o_in  = sq_less_one(radius_q);
    geom_d.i_out = inner_r * inner_r;
    geom_d.i_in  = sq_less_one(inner_r);
    // 2r-1, only used where the ramp range is not empty
    geom_d.den_o = {radius_q, 1'b0} - DEN_W'(1);
    geom_d.den_i = {inner_r, 1'b0} - DEN_W'(1);
  end

  // thresholds are registered and follow the config registers in the next cycle; first used by the band stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= '0;
    end else begin
      geom_q <= geom_d;
    end
  end

  assign cfg_o.mode   = mode_q;
  assign cfg_o.radius = radius_q;
  assign geom_o       = geom_q;

endmodule

// ===== design/rcac_dist.sv =====
`timescale 1ns / 1ps
// rcac_dist: three pipeline stages for the squared distance to the corner center
// (offset magnitudes, squares, sum). Depends on rcac_pkg.

module rcac_dist
  import rcac_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [COORD_BITS-1:0]             pos_x_i,
  input  logic [COORD_BITS-1:0]             pos_y_i,
  input  logic [SEC_W-1:0]                  section_i,
  input  cfg_t                              cfg_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2*mag_width(COORD_BITS):0]  dist_o,
  output mode_e                             mode_o,
  output tag_t                              tag_o
);

  localparam int MagW = mag_width(COORD_BITS);
  localparam int SW   = MagW + 1;
  localparam int DW   = 2 * MagW + 1;

  logic            use_fx, use_fy, sec_known;
  logic signed [SW-1:0] f_s, px_s, py_s, cx_s, cy_s, dx_s, dy_s;
  logic [MagW-1:0] mag_x, mag_y;
  tag_t            tag_a;

  logic            a_vld_q, b_vld_q, c_vld_q;
  logic            a_rdy, b_rdy, c_rdy;
  logic [MagW-1:0] a_magx_q, a_magy_q;
  mode_e           a_mode_q, b_mode_q, c_mode_q;
  tag_t            a_tag_q, b_tag_q, c_tag_q;
  logic [2*MagW-1:0] b_sqx_q, b_sqy_q;
  logic [DW-1:0]   c_dist_q;

  always_comb begin
    use_fx    = (section_i == SEC_TL) || (section_i == SEC_BL);
    use_fy    = (section_i == SEC_TL) || (section_i == SEC_TR);
    sec_known = section_i inside {SEC_TL, SEC_TR, SEC_BL, SEC_BR};
    // center coordinate r-1, which is -1 for a zero radius
    f_s  = $signed(SW'(cfg_i.radius)) - $signed(SW'(1));
    px_s = $signed(SW'(pos_x_i));
    py_s = $signed(SW'(pos_y_i));
    cx_s = use_fx ? f_s : '0;
    cy_s = use_fy ? f_s : '0;
    dx_s = px_s - cx_s;
    dy_s = py_s - cy_s;
    mag_x = dx_s[SW-1] ? MagW'(-dx_s) : MagW'(dx_s);
    mag_y = dy_s[SW-1] ? MagW'(-dy_s) : MagW'(dy_s);

    case (cfg_i.mode)
      MODE_SQUARE: begin
        tag_a.byp   = 1'b1;
        tag_a.alpha = ALPHA_OPAQUE;
      end
      MODE_ROUND, MODE_BORDER: begin
        tag_a.byp   = !sec_known;
        tag_a.alpha = ALPHA_CLEAR;
      end
      default: begin
        tag_a.byp   = 1'b1;
        tag_a.alpha = ALPHA_CLEAR;
      end
    endcase
  end

  assign c_rdy      = !c_vld_q || out_ready_i;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else begin
      if (a_rdy) a_vld_q <= in_valid_i;
      if (b_rdy) b_vld_q <= a_vld_q;
      if (c_rdy) c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && in_valid_i) begin
      a_magx_q <= mag_x;
      a_magy_q <= mag_y;
      a_mode_q <= cfg_i.mode;
      a_tag_q  <= tag_a;
    end
    if (b_rdy && a_vld_q) begin
      b_sqx_q  <= a_magx_q * a_magx_q;
      b_sqy_q  <= a_magy_q * a_magy_q;
      b_mode_q <= a_mode_q;
      b_tag_q  <= a_tag_q;
    end
    if (c_rdy && b_vld_q) begin
      c_dist_q <= DW'(b_sqx_q) + DW'(b_sqy_q);
      c_mode_q <= b_mode_q;
      c_tag_q  <= b_tag_q;
    end
  end

  assign out_valid_o = c_vld_q;
  assign dist_o      = c_dist_q;
  assign mode_o      = c_mode_q;
  assign tag_o       = c_tag_q;

endmodule

// ===== design/rcac_classify.sv =====
`timescale 1ns / 1ps
// rcac_classify: two stages that place the distance against the edge bands and
// form the ramp dividend (num * 255) and divisor. Depends on rcac_pkg.

module rcac_classify
  import rcac_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [2*mag_width(COORD_BITS):0]  dist_i,
  input  mode_e                             mode_i,
  input  tag_t                              tag_i,
  input  geom_t                             geom_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [PROD_W-1:0]                 rem_o,
  output logic [DEN_W-1:0]                  den_o,
  output logic [ALPHA_W-1:0]                quo_o,
  output logic                              byp_o
);

  localparam int DW = 2 * mag_width(COORD_BITS) + 1;

  logic [DW-1:0]    o_in, o_out, i_in, i_out;
  logic [DW-1:0]    num_w;
  logic [DEN_W-1:0] num, den;
  tag_t             tag_d;

  logic             d_vld_q, e_vld_q, d_rdy, e_rdy;
  logic [DEN_W-1:0] d_num_q, d_den_q, e_den_q;
  tag_t             d_tag_q;
  logic [PROD_W-1:0] e_rem_q;
  logic [ALPHA_W-1:0] e_quo_q;
  logic             e_byp_q;

  always_comb begin
    o_in  = DW'(geom_i.o_in);
    o_out = DW'(geom_i.o_out);
    i_in  = DW'(geom_i.i_in);
    i_out = DW'(geom_i.i_out);
    tag_d = tag_i;
    num_w = '0;
    den   = geom_i.den_o;
    if (!tag_i.byp) begin
      tag_d.alpha = ALPHA_CLEAR;
      case (mode_i)
        MODE_ROUND: begin
          if (dist_i <= o_in) begin
            tag_d.byp   = 1'b1;
            tag_d.alpha = ALPHA_OPAQUE;
          end else if (dist_i >= o_out) begin
            tag_d.byp = 1'b1;
          end else begin
            num_w = o_out - dist_i;
          end
        end
        MODE_BORDER: begin
          if (dist_i < i_in) begin
            tag_d.byp = 1'b1;
          end else if (dist_i < i_out) begin
            // ramp up across the inner edge
            num_w = dist_i - i_in;
            den   = geom_i.den_i;
          end else if (dist_i < o_in) begin
            tag_d.byp   = 1'b1;
            tag_d.alpha = ALPHA_OPAQUE;
          end else if (dist_i < o_out) begin
            num_w = o_out - dist_i;
          end else begin
            tag_d.byp = 1'b1;
          end
        end
        default: begin
          tag_d.byp = 1'b1;
        end
      endcase
    end
    // in a ramp band the numerator never exceeds the band width
    num = num_w[DEN_W-1:0];
  end

  assign e_rdy      = !e_vld_q || out_ready_i;
  assign d_rdy      = !d_vld_q || e_rdy;
  assign in_ready_o = d_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else begin
      if (d_rdy) d_vld_q <= in_valid_i;
      if (e_rdy) e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (d_rdy && in_valid_i) begin
      d_num_q <= num;
      d_den_q <= den;
      d_tag_q <= tag_d;
    end
    if (e_rdy && d_vld_q) begin
      e_rem_q <= {d_num_q, ALPHA_W'(0)} - PROD_W'(d_num_q);
      e_den_q <= d_den_q;
      e_quo_q <= d_tag_q.byp ? d_tag_q.alpha : ALPHA_CLEAR;
      e_byp_q <= d_tag_q.byp;
    end
  end

  assign out_valid_o = e_vld_q;
  assign rem_o       = e_rem_q;
  assign den_o       = e_den_q;
  assign quo_o       = e_quo_q;
  assign byp_o       = e_byp_q;

endmodule

// ===== design/rcac_div_stage.sv =====
`timescale 1ns / 1ps
// rcac_div_stage: one stage of the restoring divider, two quotient bits per stage.
// Depends on rcac_pkg.

module rcac_div_stage
  import rcac_pkg::*;
#(
  parameter int BIT_HI = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PROD_W-1:0]   rem_i,
  input  logic [DEN_W-1:0]    den_i,
  input  logic [ALPHA_W-1:0]  quo_i,
  input  logic                byp_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PROD_W-1:0]   rem_o,
  output logic [DEN_W-1:0]    den_o,
  output logic [ALPHA_W-1:0]  quo_o,
  output logic                byp_o
);

  logic [PROD_W-1:0]  rem, sub;
  logic [ALPHA_W-1:0] quo;
  logic               vld_q, rdy;
  logic [PROD_W-1:0]  rem_q;
  logic [DEN_W-1:0]   den_q;
  logic [ALPHA_W-1:0] quo_q;
  logic               byp_q;

  always_comb begin
    rem = rem_i;
    quo = quo_i;
    sub = '0;
    for (int j = 0; j < DIV_BITS; j++) begin
      sub = PROD_W'(den_i) << (BIT_HI - j);
      if (!byp_i && (rem >= sub)) begin
        rem = rem - sub;
        quo[BIT_HI - j] = 1'b1;
      end
    end
  end

  assign rdy        = !vld_q || out_ready_i;
  assign in_ready_o = rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (rdy) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy && in_valid_i) begin
      rem_q <= rem;
      den_q <= den_i;
      quo_q <= quo;
      byp_q <= byp_i;
    end
  end

  assign out_valid_o = vld_q;
  assign rem_o       = rem_q;
  assign den_o       = den_q;
  assign quo_o       = quo_q;
  assign byp_o       = byp_q;

endmodule

// ===== test/tb_rounded_corner_alpha_coverage.sv =====
`timescale 1ns / 1ps
// tb_rounded_corner_alpha_coverage: self-checking bench for the corner coverage block.
// Directed table first, then random phases per shape setting; depends on rcac_pkg
// and rounded_corner_alpha_coverage.

module tb_rounded_corner_alpha_coverage;
  import rcac_pkg::*;

  localparam int CB           = 10;
  localparam int CB_MAX       = (1 << CB) - 1;
  localparam int DIR_N        = 25;
  localparam int NPH          = 14;
  localparam int PHASE_ITEMS  = 65;
  localparam int DRAIN_CYCLES = 20;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int MAX_REPORTS  = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [SEC_W-1:0]     SEC_OTHER = 3'd4;
  localparam logic [SEC_W-1:0]     SEC_MAX   = 3'd7;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [CB-1:0]         pos_x_i     = '0;
  logic [CB-1:0]         pos_y_i     = '0;
  logic [SEC_W-1:0]      section_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ALPHA_W-1:0]    alpha_o;

  // register copies as the block should hold them
  mode_e            cfg_mode   = MODE_SQUARE;
  logic [RAD_W-1:0] cfg_radius = RADIUS_RST;
  logic [RAD_W-1:0] cfg_thick  = THICK_RST;

  // typed-in expectation for the request on the bus
  logic               pin_en    = 1'b0;
  logic [ALPHA_W-1:0] pin_alpha = '0;

  logic [ALPHA_W-1:0] alpha_due_q [$];
  logic [ALPHA_W-1:0] want_alpha;
  int                 n_fail   = 0;
  int                 send_pct = 0;
  int                 recv_pct = 0;

  typedef struct packed {
    mode_e              mode;
    logic [RAD_W-1:0]   radius;
    logic [RAD_W-1:0]   thick;
    logic [CB-1:0]      x;
    logic [CB-1:0]      y;
    logic [SEC_W-1:0]   sec;
    logic               chk;
    logic [ALPHA_W-1:0] alpha;
  } vec_t;

  // mode, radius, thickness, x, y, section, typed, alpha
  vec_t dir_tab [DIR_N] = '{
    '{MODE_SQUARE, 10'd8,    10'd1,    10'd0,    10'd0,    SEC_TL,    1'b1, ALPHA_OPAQUE},
    '{MODE_SQUARE, 10'd8,    10'd1,    10'd1023, 10'd1023, SEC_MAX,   1'b1, ALPHA_OPAQUE},
    '{MODE_SQUARE, 10'd8,    10'd1,    10'd1023, 10'd0,    SEC_OTHER, 1'b1, ALPHA_OPAQUE},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd0,    10'd0,    SEC_BR,    1'b1, ALPHA_OPAQUE},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd7,    10'd7,    SEC_TL,    1'b1, ALPHA_OPAQUE},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd1023, 10'd1023, SEC_BR,    1'b1, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd3,    10'd3,    SEC_OTHER, 1'b1, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd7,    10'd3,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd0,    10'd4,    SEC_TR,    1'b0, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd6,    10'd0,    SEC_BL,    1'b0, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd8,    10'd1,    10'd0,    10'd0,    SEC_TL,    1'b0, ALPHA_CLEAR},
    '{MODE_UNUSED, 10'd8,    10'd1,    10'd0,    10'd0,    SEC_BR,    1'b1, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd0,    10'd1,    10'd0,    10'd0,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd0,    10'd1,    10'd1,    10'd0,    SEC_TL,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd8,    10'd0,    10'd0,    SEC_BR,    1'b1, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd1023, 10'd0,    10'd0,    SEC_BR,    1'b1, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd3,    10'd4,    10'd2,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd3,    10'd5,    10'd2,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd3,    10'd7,    10'd1,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd3,    10'd10,   10'd10,   SEC_BR,    1'b1, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd8,    10'd3,    10'd1,    10'd1,    SEC_OTHER, 1'b1, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd0,    10'd0,    10'd0,    10'd0,    SEC_BR,    1'b0, ALPHA_CLEAR},
    '{MODE_ROUND,  10'd1023, 10'd0,    10'd0,    10'd0,    SEC_TL,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd1023, 10'd1,    10'd1023, 10'd0,    SEC_TR,    1'b0, ALPHA_CLEAR},
    '{MODE_BORDER, 10'd1,    10'd0,    10'd0,    10'd0,    SEC_BR,    1'b0, ALPHA_CLEAR}
  };

  // shape settings of the random phases; a negative radius means pick at random
  mode_e plan_mode [NPH] = '{MODE_ROUND, MODE_BORDER, MODE_ROUND, MODE_BORDER, MODE_ROUND,
                             MODE_BORDER, MODE_UNUSED, MODE_BORDER, MODE_ROUND, MODE_BORDER,
                             MODE_ROUND, MODE_BORDER, MODE_SQUARE, MODE_BORDER};
  int plan_radius [NPH] = '{8, 8, 0, 1023, 1023, 5, 8, 16, 1, 1023, -1, -1, -1, 2};
  int plan_thick  [NPH] = '{1, 3, 0, 1023, 0, 10, 1, 0, 1, 1, -1, -1, -1, 1};

  rounded_corner_alpha_coverage #(
    .COORD_BITS(CB)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .section_i  (section_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .alpha_o    (alpha_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ALPHA_W-1:0] ramp_alpha(longint num, longint den);
    if (den <= 0 || num <= 0) begin
      return ALPHA_CLEAR;
    end
    return ALPHA_W'((num * 255) / den);
  endfunction

  function automatic logic [ALPHA_W-1:0] coverage_alpha(mode_e m, logic [RAD_W-1:0] rad,
      logic [RAD_W-1:0] thk, logic [CB-1:0] x, logic [CB-1:0] y, logic [SEC_W-1:0] sec);
    longint r, t, f, px, py, cx, cy, d, ir, i_in, i_out, o_in, o_out;
    r  = rad;
    t  = thk;
    px = x;
    py = y;
    if (m == MODE_SQUARE) begin
      return ALPHA_OPAQUE;
    end
    if (m == MODE_UNUSED || sec > SEC_BR) begin
      return ALPHA_CLEAR;
    end
    f     = r - 1;
    cx    = (sec == SEC_TL || sec == SEC_BL) ? f : 0;
    cy    = (sec == SEC_TL || sec == SEC_TR) ? f : 0;
    d     = (px - cx) * (px - cx) + (py - cy) * (py - cy);
    o_in  = f * f;
    o_out = r * r;
    if (m == MODE_ROUND) begin
      if (d <= o_in) return ALPHA_OPAQUE;
      if (d >= o_out) return ALPHA_CLEAR;
      return ramp_alpha(o_out - d, o_out - o_in);
    end
    ir    = (r < t) ? 0 : r - t;
    i_in  = (ir - 1) * (ir - 1);
    i_out = ir * ir;
    if (d < i_in) return ALPHA_CLEAR;
    if (d < i_out) return ramp_alpha(d - i_in, i_out - i_in);
    if (d < o_in) return ALPHA_OPAQUE;
    if (d < o_out) return ramp_alpha(o_out - d, o_out - o_in);
    return ALPHA_CLEAR;
  endfunction

  task automatic send_item(input logic [CB-1:0] x, input logic [CB-1:0] y,
      input logic [SEC_W-1:0] s, input logic pin, input logic [ALPHA_W-1:0] pin_val);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i    <= x;
    pos_y_i    <= y;
    section_i  <= s;
    pin_en     <= pin;
    pin_alpha  <= pin_val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // most pixels land near the corner, a share right on the inner or outer edge
  task automatic send_pixel();
    int r, span, tr, cx, cy, dx, rem, dy, yv;
    logic [CB-1:0] x, y;
    logic [SEC_W-1:0] s;
    r    = cfg_radius;
    span = 2 * r + 2;
    if (span > CB_MAX) span = CB_MAX;
    s = SEC_W'($urandom_range(3));
    x = CB'($urandom_range(span));
    y = CB'($urandom_range(span));
    case ($urandom_range(9))
      0, 1: begin
        x = CB'($urandom);
        y = CB'($urandom);
        s = SEC_W'($urandom);
      end
      2, 3, 4, 5: begin
        tr = r;
        if (cfg_mode == MODE_BORDER && $urandom_range(1) == 1) begin
          tr = (r > int'(cfg_thick)) ? r - int'(cfg_thick) : 0;
        end
        cx  = (s == SEC_TL || s == SEC_BL) ? r - 1 : 0;
        cy  = (s == SEC_TL || s == SEC_TR) ? r - 1 : 0;
        dx  = int'(x) - cx;
        rem = tr * tr - dx * dx;
        if (rem >= 0) begin
          dy = int'($sqrt(real'(rem))) + int'($urandom_range(2)) - 1;
          yv = ($urandom_range(1) == 1) ? cy + dy : cy - dy;
          if (yv < 0) yv = 0;
          if (yv > CB_MAX) yv = CB_MAX;
          y = CB'(yv);
        end
      end
      default: ;
    endcase
    send_item(x, y, s, 1'b0, ALPHA_CLEAR);
  endtask

  // waits until every request has come back, then writes all registers
  task automatic apply_config(input mode_e m, input logic [RAD_W-1:0] r,
      input logic [RAD_W-1:0] t);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (alpha_due_q.size() != 0);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_SHAPE_MODE;
    cfg_wdata_i <= CFG_DATA_W'(m);
    @(negedge clk_i);
    cfg_idx_i   <= CFG_CORNER_RADIUS;
    cfg_wdata_i <= r;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_BORDER_THICK;
    cfg_wdata_i <= t;
    @(negedge clk_i);
    // unmapped index, must leave the shape alone
    cfg_idx_i   <= CFG_SPARE;
    cfg_wdata_i <= CFG_DATA_W'($urandom);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_mode   = m;
    cfg_radius = r;
    cfg_thick  = t;
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_pct);
  end

  // request side is logged before the result side so a result in the same cycle as its request still lines up
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        alpha_due_q.push_back(pin_en ? pin_alpha :
            coverage_alpha(cfg_mode, cfg_radius, cfg_thick, pos_x_i, pos_y_i, section_i));
      end
      if (out_valid_o && !out_stall_i) begin
        if (alpha_due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS) begin
            $display("%0t: alpha %0d with no request pending", $realtime, alpha_o);
          end
        end else begin
          want_alpha = alpha_due_q.pop_front();
          if (alpha_o !== want_alpha) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
              $display("%0t: alpha mismatch, expected %0d, got %0d",
                       $realtime, want_alpha, alpha_o);
            end
          end
        end
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAILURE");
    $finish;
  end

  initial begin
    int p, n;
    logic [RAD_W-1:0] r, t;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (n = 0; n < DIR_N; n++) begin
      if (dir_tab[n].mode != cfg_mode || dir_tab[n].radius != cfg_radius ||
          dir_tab[n].thick != cfg_thick) begin
        apply_config(dir_tab[n].mode, dir_tab[n].radius, dir_tab[n].thick);
      end
      send_item(dir_tab[n].x, dir_tab[n].y, dir_tab[n].sec, dir_tab[n].chk,
                dir_tab[n].alpha);
    end

    for (p = 0; p < NPH; p++) begin
      r = RAD_W'(plan_radius[p]);
      t = RAD_W'(plan_thick[p]);
      if (plan_radius[p] < 0) begin
        r = RAD_W'($urandom_range(60, 2));
        t = RAD_W'($urandom_range(r));
      end
      apply_config(plan_mode[p], r, t);
      case (p % 4)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 75; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 75; end
        default: begin send_pct = 37; recv_pct = 37; end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_pixel();
      end
    end

    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (alpha_due_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rcac_pkg.sv
design/rcac_cfg.sv
design/rcac_dist.sv
design/rcac_classify.sv
design/rcac_div_stage.sv
design/rounded_corner_alpha_coverage.sv
test/tb_rounded_corner_alpha_coverage.sv
